[rtl/core/rover_avoidance_fsm_assert.svh]
// Assertion macros used by the rover avoidance top level.
`ifndef ROVER_AVOIDANCE_FSM_ASSERT_SVH
`define ROVER_AVOIDANCE_FSM_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RAV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define RAV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rav_pkg.sv]
// Types, codes and mode helpers for the rover avoidance controller.
`default_nettype none

package rav_pkg;

  localparam logic OP_SENSOR = 1'b0;
  localparam logic OP_MANUAL = 1'b1;

  localparam logic [2:0] CFG_TUNNEL_LIMIT = 3'd0;
  localparam logic [2:0] CFG_GROUND_LIMIT = 3'd1;
  localparam logic [2:0] CFG_OBJECT_LIMIT = 3'd2;
  localparam logic [2:0] CFG_HOLD_TIME    = 3'd3;
  localparam logic [2:0] CFG_HALL_LIMIT   = 3'd4;
  localparam logic [2:0] CFG_HALL_ENABLE  = 3'd5;

  localparam logic [7:0]  TUNNEL_LIMIT_RST = 8'd5;
  localparam logic [7:0]  GROUND_LIMIT_RST = 8'd10;
  localparam logic [7:0]  OBJECT_LIMIT_RST = 8'd20;
  localparam logic [15:0] HOLD_TIME_RST    = 16'd2500;
  localparam logic [9:0]  HALL_LIMIT_RST   = 10'd561;

  localparam logic [3:0] MODE_STILL        = 4'd0;
  localparam logic [3:0] MODE_FORWARD      = 4'd1;
  localparam logic [3:0] MODE_BORDER_LEFT  = 4'd2;
  localparam logic [3:0] MODE_BORDER_RIGHT = 4'd3;
  localparam logic [3:0] MODE_FRONT_BACK   = 4'd4;
  localparam logic [3:0] MODE_FRONT_LEFT   = 4'd5;
  localparam logic [3:0] MODE_FRONT_RIGHT  = 4'd6;
  localparam logic [3:0] MODE_OBJECT_LEFT  = 4'd7;
  localparam logic [3:0] MODE_OBJECT_RIGHT = 4'd8;
  localparam logic [3:0] MODE_OVR_FORWARD  = 4'd9;
  localparam logic [3:0] MODE_OVR_LEFT     = 4'd10;
  localparam logic [3:0] MODE_OVR_RIGHT    = 4'd11;
  localparam logic [3:0] MODE_OVR_BACK     = 4'd12;
  localparam logic [3:0] MODE_MAGNET       = 4'd13;
  localparam logic [3:0] MODE_TUNNEL_LEFT  = 4'd14;
  localparam logic [3:0] MODE_TUNNEL_RIGHT = 4'd15;

  // pin bits: 0 lf, 1 lb, 2 le, 3 rf, 4 rb, 5 re
  localparam logic [5:0] PINS_STOP  = 6'h00;
  localparam logic [5:0] PINS_FWD   = 6'h2D;
  localparam logic [5:0] PINS_LEFT  = 6'h35;
  localparam logic [5:0] PINS_RIGHT = 6'h2E;
  localparam logic [5:0] PINS_BACK  = 6'h36;

  typedef struct packed {
    logic [7:0]  tunnel_limit;
    logic [7:0]  ground_limit;
    logic [7:0]  object_limit;
    logic [15:0] hold_time_ms;
    logic [9:0]  hall_limit;
    logic        hall_enable;
  } cfg_t;

  typedef struct packed {
    logic        operation;
    logic [31:0] now_ms;
    logic [7:0]  front_distance;
    logic [7:0]  left_distance;
    logic [7:0]  right_distance;
    logic [7:0]  ground_distance;
    logic        left_border_seen;
    logic        right_border_seen;
    logic [9:0]  hall_level;
    logic [3:0]  command_mode;
    logic        command_auto;
  } item_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [31:0] entry_time;
    logic        side;
    logic        auto_on;
    logic [5:0]  pins;
  } nav_state_t;

  typedef struct packed {
    nav_state_t st;
    logic       changed;
  } step_t;

  function automatic logic [5:0] mode_pins(input logic [3:0] m);
    logic [5:0] p;
    case (m)
      MODE_STILL:        p = PINS_STOP;
      MODE_FORWARD:      p = PINS_FWD;
      MODE_BORDER_LEFT:  p = PINS_RIGHT;
      MODE_BORDER_RIGHT: p = PINS_LEFT;
      MODE_FRONT_BACK:   p = PINS_BACK;
      MODE_FRONT_LEFT:   p = PINS_LEFT;
      MODE_FRONT_RIGHT:  p = PINS_RIGHT;
      MODE_OBJECT_LEFT:  p = PINS_LEFT;
      MODE_OBJECT_RIGHT: p = PINS_RIGHT;
      MODE_OVR_FORWARD:  p = PINS_FWD;
      MODE_OVR_LEFT:     p = PINS_LEFT;
      MODE_OVR_RIGHT:    p = PINS_RIGHT;
      MODE_OVR_BACK:     p = PINS_BACK;
      MODE_MAGNET:       p = PINS_STOP;
      MODE_TUNNEL_LEFT:  p = PINS_RIGHT;
      MODE_TUNNEL_RIGHT: p = PINS_LEFT;
      default:           p = PINS_STOP;
    endcase
    return p;
  endfunction

  function automatic step_t enter_mode(input step_t s, input logic [3:0] m,
                                       input logic [31:0] now, input logic sig);
    step_t r;
    r = s;
    if (m != s.st.mode) begin
      r.st.mode       = m;
      r.st.entry_time = now;
      r.st.pins       = mode_pins(m);
      if (m == MODE_BORDER_LEFT) r.st.side = 1'b0;
      if (m == MODE_BORDER_RIGHT) r.st.side = 1'b1;
      if (sig) r.changed = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/rav_nav.sv]
// Next-state logic for one transaction: manual command or sensor evaluation.
`default_nettype none

module rav_nav
  import rav_pkg::*;
(
  input  wire cfg_t       cfg,
  input  wire nav_state_t state,
  input  wire item_t      item,
  output step_t           nxt
);

  logic [31:0] elapsed;
  logic        timed_out;
  logic        magnet;
  logic        left_tunnel;
  logic        right_tunnel;
  step_t       s;

  assign elapsed      = item.now_ms - state.entry_time;
  assign timed_out    = elapsed > {16'd0, cfg.hold_time_ms};
  assign magnet       = cfg.hall_enable && (item.hall_level < cfg.hall_limit);
  assign left_tunnel  = item.left_distance <= cfg.tunnel_limit;
  assign right_tunnel = item.right_distance <= cfg.tunnel_limit;

  always_comb begin
    s.st      = state;
    s.changed = 1'b0;
    if (item.operation == OP_MANUAL) begin
      s = enter_mode(s, item.command_mode, item.now_ms, 1'b0);
      s.st.auto_on = item.command_auto;
    end else if (state.auto_on) begin
      if (magnet) begin
        s = enter_mode(s, MODE_MAGNET, item.now_ms, 1'b1);
      end else begin
        if (left_tunnel) begin
          s = enter_mode(s, MODE_TUNNEL_LEFT, item.now_ms, 1'b1);
        end else if (right_tunnel) begin
          s = enter_mode(s, MODE_TUNNEL_RIGHT, item.now_ms, 1'b1);
        end else if ((item.left_border_seen && item.right_border_seen) ||
                     (item.ground_distance > cfg.ground_limit)) begin
          s = enter_mode(s, MODE_FRONT_BACK, item.now_ms, 1'b1);
        end else if (item.left_border_seen) begin
          s = enter_mode(s, MODE_BORDER_LEFT, item.now_ms, 1'b1);
        end else if (item.right_border_seen) begin
          s = enter_mode(s, MODE_BORDER_RIGHT, item.now_ms, 1'b1);
        end else if (item.front_distance <= cfg.object_limit) begin
          s = enter_mode(s, s.st.side ? MODE_OBJECT_LEFT : MODE_OBJECT_RIGHT,
                         item.now_ms, 1'b1);
        end

        // exits chain in this order, all against the same elapsed time
        if (s.st.mode == MODE_TUNNEL_LEFT && !left_tunnel)
          s = enter_mode(s, MODE_FORWARD, item.now_ms, 1'b1);
        if (s.st.mode == MODE_TUNNEL_RIGHT && !right_tunnel)
          s = enter_mode(s, MODE_FORWARD, item.now_ms, 1'b1);
        if (s.st.mode == MODE_FRONT_BACK && timed_out)
          s = enter_mode(s, s.st.side ? MODE_FRONT_LEFT : MODE_FRONT_RIGHT,
                         item.now_ms, 1'b1);
        if (s.st.mode == MODE_FRONT_RIGHT && timed_out)
          s = enter_mode(s, MODE_FORWARD, item.now_ms, 1'b1);
        if (s.st.mode == MODE_FRONT_LEFT && timed_out)
          s = enter_mode(s, MODE_FORWARD, item.now_ms, 1'b1);
        if (s.st.mode == MODE_BORDER_LEFT && !item.left_border_seen)
          s = enter_mode(s, MODE_FORWARD, item.now_ms, 1'b1);
        if (s.st.mode == MODE_BORDER_RIGHT && !item.right_border_seen)
          s = enter_mode(s, MODE_FORWARD, item.now_ms, 1'b1);
        if (s.st.mode == MODE_OBJECT_LEFT && timed_out)
          s = enter_mode(s, MODE_FORWARD, item.now_ms, 1'b1);
        if (s.st.mode == MODE_OBJECT_RIGHT && timed_out)
          s = enter_mode(s, MODE_FORWARD, item.now_ms, 1'b1);
      end
    end
  end

  assign nxt = s;

endmodule

`default_nettype wire

[rtl/core/rover_avoidance_fsm.sv]
// Top level of the rover navigation mode controller.
`default_nettype none

// Takes one transaction per clock: a sensor evaluation or a manual mode command. Each
// transaction is captured in an input register; the mode update logic between that register
// and the result register (detection priority, then the chained exits) is combinational, so one
// transaction per cycle is sustained while out_ready stays high. The navigation state is updated
// as the result is registered, so each transaction sees the state left by the one before it.
// Configuration writes take effect on the next clock and are meant to be made while no
// transaction is in flight.

`include "rover_avoidance_fsm_assert.svh"

module rover_avoidance_fsm
  import rav_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [31:0] now_ms,
  input  wire logic [7:0]  front_distance,
  input  wire logic [7:0]  left_distance,
  input  wire logic [7:0]  right_distance,
  input  wire logic [7:0]  ground_distance,
  input  wire logic        left_border_seen,
  input  wire logic        right_border_seen,
  input  wire logic [9:0]  hall_level,
  input  wire logic [3:0]  command_mode,
  input  wire logic        command_auto,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       mode,
  output logic             border_side,
  output logic             left_forward,
  output logic             left_backward,
  output logic             left_enable,
  output logic             right_forward,
  output logic             right_backward,
  output logic             right_enable,
  output logic             mode_changed,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t       cfg;
  nav_state_t state;
  item_t      in_item;
  item_t      s1_item;
  logic       s1_valid;
  step_t      nxt;
  logic       advance;
  logic       step_fire;
  logic [3:0] res_mode;
  logic       res_side;
  logic [5:0] res_pins;
  logic       res_changed;

  assign in_item = '{
    operation:         operation,
    now_ms:            now_ms,
    front_distance:    front_distance,
    left_distance:     left_distance,
    right_distance:    right_distance,
    ground_distance:   ground_distance,
    left_border_seen:  left_border_seen,
    right_border_seen: right_border_seen,
    hall_level:        hall_level,
    command_mode:      command_mode,
    command_auto:      command_auto
  };

  assign advance   = !out_valid || out_ready;
  assign in_ready  = !s1_valid || advance;
  assign step_fire = s1_valid && advance;

  rav_nav u_nav (
    .cfg   (cfg),
    .state (state),
    .item  (s1_item),
    .nxt   (nxt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      state.mode       <= MODE_FORWARD;
      state.entry_time <= 32'd0;
      state.side       <= 1'b0;
      state.auto_on    <= 1'b0;
      state.pins       <= PINS_STOP;
      cfg.tunnel_limit <= TUNNEL_LIMIT_RST;
      cfg.ground_limit <= GROUND_LIMIT_RST;
      cfg.object_limit <= OBJECT_LIMIT_RST;
      cfg.hold_time_ms <= HOLD_TIME_RST;
      cfg.hall_limit   <= HALL_LIMIT_RST;
      cfg.hall_enable  <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (advance) out_valid <= s1_valid;
      if (step_fire) state <= nxt.st;
      if (cfg_write) begin
        case (cfg_index)
          CFG_TUNNEL_LIMIT: cfg.tunnel_limit <= cfg_data[7:0];
          CFG_GROUND_LIMIT: cfg.ground_limit <= cfg_data[7:0];
          CFG_OBJECT_LIMIT: cfg.object_limit <= cfg_data[7:0];
          CFG_HOLD_TIME:    cfg.hold_time_ms <= cfg_data;
          CFG_HALL_LIMIT:   cfg.hall_limit   <= cfg_data[9:0];
          CFG_HALL_ENABLE:  cfg.hall_enable  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_item <= in_item;
    if (step_fire) begin
      res_mode    <= nxt.st.mode;
      res_side    <= nxt.st.side;
      res_pins    <= nxt.st.pins;
      res_changed <= nxt.changed;
    end
  end

  assign mode           = res_mode;
  assign border_side    = res_side;
  assign left_forward   = res_pins[0];
  assign left_backward  = res_pins[1];
  assign left_enable    = res_pins[2];
  assign right_forward  = res_pins[3];
  assign right_backward = res_pins[4];
  assign right_enable   = res_pins[5];
  assign mode_changed   = res_changed;

  `RAV_ASSERT_NEXT(a_manual_no_change,
    step_fire && s1_item.operation == OP_MANUAL, !mode_changed,
    "manual transaction flagged a mode change")
  `RAV_ASSERT_NEXT(a_pins_follow_mode,
    step_fire && nxt.st.mode != state.mode, state.pins == mode_pins(state.mode),
    "motor pins do not match new mode")
  `RAV_ASSERT_NEXT(a_state_hold_idle,
    !step_fire, $stable(state),
    "navigation state moved without a transaction")
  `RAV_ASSERT_NEXT(a_auto_off_hold,
    step_fire && s1_item.operation == OP_SENSOR && !state.auto_on, $stable(state),
    "sensor step changed state with auto off")

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the rover avoidance mode controller: scripted and random transactions.
module tb;
  import rav_pkg::*;

  localparam int TIME_LIMIT = 8_000_000;
  localparam int DRAIN_SLACK = 6;
  localparam int ITEMS_PER_SETTING = 175;
  localparam int STALL_CYCLES = 64;
  localparam logic [2:0] CFG_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [3:0] mode;
    logic       side;
    logic [5:0] pins;
    logic       changed;
  } nav_result_t;

  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  idx;
    logic [15:0] val;
    item_t       it;
    logic        known;
    nav_result_t res;
  } script_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        operation;
  logic [31:0] now_ms;
  logic [7:0]  front_distance;
  logic [7:0]  left_distance;
  logic [7:0]  right_distance;
  logic [7:0]  ground_distance;
  logic        left_border_seen;
  logic        right_border_seen;
  logic [9:0]  hall_level;
  logic [3:0]  command_mode;
  logic        command_auto;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  mode;
  logic        border_side;
  logic        left_forward;
  logic        left_backward;
  logic        left_enable;
  logic        right_forward;
  logic        right_backward;
  logic        right_enable;
  logic        mode_changed;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  rover_avoidance_fsm i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .now_ms           (now_ms),
    .front_distance   (front_distance),
    .left_distance    (left_distance),
    .right_distance   (right_distance),
    .ground_distance  (ground_distance),
    .left_border_seen (left_border_seen),
    .right_border_seen(right_border_seen),
    .hall_level       (hall_level),
    .command_mode     (command_mode),
    .command_auto     (command_auto),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .mode             (mode),
    .border_side      (border_side),
    .left_forward     (left_forward),
    .left_backward    (left_backward),
    .left_enable      (left_enable),
    .right_forward    (right_forward),
    .right_backward   (right_backward),
    .right_enable     (right_enable),
    .mode_changed     (mode_changed),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // navigation predictor state and limits
  logic [3:0]  cur_mode;
  logic [31:0] mode_since;
  logic        last_side;
  logic        autonomous;
  logic [5:0]  drive_pins;
  logic        step_signalled;
  logic [7:0]  lim_tunnel;
  logic [7:0]  lim_ground;
  logic [7:0]  lim_object;
  logic [15:0] lim_hold;
  logic [9:0]  lim_hall;
  logic        hall_on;
  logic [15:0] modes_hit;

  nav_result_t nav_expect_q[$];
  script_row_t script_q[$];
  int          errors;
  int          sent;
  int          results_seen;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic [31:0] sim_ms;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIME_LIMIT);
    $display("tb: failure");
    $finish;
  end

  function automatic logic [5:0] pins_for(input logic [3:0] m);
    case (m)
      MODE_FORWARD, MODE_OVR_FORWARD: return PINS_FWD;
      MODE_BORDER_LEFT, MODE_FRONT_RIGHT, MODE_OBJECT_RIGHT, MODE_OVR_RIGHT,
      MODE_TUNNEL_LEFT: return PINS_RIGHT;
      MODE_BORDER_RIGHT, MODE_FRONT_LEFT, MODE_OBJECT_LEFT, MODE_OVR_LEFT,
      MODE_TUNNEL_RIGHT: return PINS_LEFT;
      MODE_FRONT_BACK, MODE_OVR_BACK: return PINS_BACK;
      default: return PINS_STOP;
    endcase
  endfunction

  task automatic switch_mode(input logic [3:0] m, input logic [31:0] t, input logic sig);
    if (m != cur_mode) begin
      cur_mode = m;
      mode_since = t;
      drive_pins = pins_for(m);
      if (m == MODE_BORDER_LEFT) last_side = 1'b0;
      if (m == MODE_BORDER_RIGHT) last_side = 1'b1;
      if (sig) step_signalled = 1'b1;
      modes_hit[m] = 1'b1;
    end
  endtask

  task automatic predict_step(input item_t it, output nav_result_t r);
    logic [31:0] since;
    logic        late;
    step_signalled = 1'b0;
    if (it.operation == OP_MANUAL) begin
      switch_mode(it.command_mode, it.now_ms, 1'b0);
      autonomous = it.command_auto;
    end else if (autonomous) begin
      since = it.now_ms - mode_since;
      late = since > {16'd0, lim_hold};
      if (hall_on && it.hall_level < lim_hall) begin
        switch_mode(MODE_MAGNET, it.now_ms, 1'b1);
      end else begin
        if (it.left_distance <= lim_tunnel)
          switch_mode(MODE_TUNNEL_LEFT, it.now_ms, 1'b1);
        else if (it.right_distance <= lim_tunnel)
          switch_mode(MODE_TUNNEL_RIGHT, it.now_ms, 1'b1);
        else if ((it.left_border_seen && it.right_border_seen) ||
                 it.ground_distance > lim_ground)
          switch_mode(MODE_FRONT_BACK, it.now_ms, 1'b1);
        else if (it.left_border_seen)
          switch_mode(MODE_BORDER_LEFT, it.now_ms, 1'b1);
        else if (it.right_border_seen)
          switch_mode(MODE_BORDER_RIGHT, it.now_ms, 1'b1);
        else if (it.front_distance <= lim_object)
          switch_mode(last_side ? MODE_OBJECT_LEFT : MODE_OBJECT_RIGHT, it.now_ms, 1'b1);

        // exits chain on the elapsed time taken at the start of the step
        if (cur_mode == MODE_TUNNEL_LEFT && it.left_distance > lim_tunnel)
          switch_mode(MODE_FORWARD, it.now_ms, 1'b1);
        if (cur_mode == MODE_TUNNEL_RIGHT && it.right_distance > lim_tunnel)
          switch_mode(MODE_FORWARD, it.now_ms, 1'b1);
        if (cur_mode == MODE_FRONT_BACK && late)
          switch_mode(last_side ? MODE_FRONT_LEFT : MODE_FRONT_RIGHT, it.now_ms, 1'b1);
        if (cur_mode == MODE_FRONT_RIGHT && late)
          switch_mode(MODE_FORWARD, it.now_ms, 1'b1);
        if (cur_mode == MODE_FRONT_LEFT && late)
          switch_mode(MODE_FORWARD, it.now_ms, 1'b1);
        if (cur_mode == MODE_BORDER_LEFT && !it.left_border_seen)
          switch_mode(MODE_FORWARD, it.now_ms, 1'b1);
        if (cur_mode == MODE_BORDER_RIGHT && !it.right_border_seen)
          switch_mode(MODE_FORWARD, it.now_ms, 1'b1);
        if (cur_mode == MODE_OBJECT_LEFT && late)
          switch_mode(MODE_FORWARD, it.now_ms, 1'b1);
        if (cur_mode == MODE_OBJECT_RIGHT && late)
          switch_mode(MODE_FORWARD, it.now_ms, 1'b1);
      end
    end
    r.mode = cur_mode;
    r.side = last_side;
    r.pins = drive_pins;
    r.changed = step_signalled;
  endtask

  function automatic item_t sense(input logic [31:0] t, input logic [7:0] fd,
                                  input logic [7:0] ld, input logic [7:0] rd,
                                  input logic [7:0] gd, input logic lb, input logic rb,
                                  input logic [9:0] hall);
    item_t it;
    it.operation = OP_SENSOR;
    it.now_ms = t;
    it.front_distance = fd;
    it.left_distance = ld;
    it.right_distance = rd;
    it.ground_distance = gd;
    it.left_border_seen = lb;
    it.right_border_seen = rb;
    it.hall_level = hall;
    it.command_mode = 4'hF;
    it.command_auto = 1'b1;
    return it;
  endfunction

  function automatic item_t manual(input logic [31:0] t, input logic [3:0] m, input logic a);
    item_t it;
    it = sense(t, 8'hFF, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, 10'h000);
    it.operation = OP_MANUAL;
    it.command_mode = m;
    it.command_auto = a;
    return it;
  endfunction

  function automatic nav_result_t shows(input logic [3:0] m, input logic s,
                                        input logic [5:0] p, input logic c);
    nav_result_t r;
    r.mode = m;
    r.side = s;
    r.pins = p;
    r.changed = c;
    return r;
  endfunction

  task automatic add(input item_t it, input logic known, input nav_result_t res);
    script_row_t row;
    row = '0;
    row.it = it;
    row.known = known;
    row.res = res;
    script_q.push_back(row);
  endtask

  task automatic add_cfg(input logic [2:0] idx, input logic [15:0] val);
    script_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    script_q.push_back(row);
  endtask

  task automatic flag(input string what, input nav_result_t w, input nav_result_t g);
    errors++;
    if (errors <= 10)
      $display("mismatch (%s): expected mode %0d side %0b pins %b chg %0b, got mode %0d side %0b pins %b chg %0b",
               what, w.mode, w.side, w.pins, w.changed, g.mode, g.side, g.pins, g.changed);
  endtask

  task automatic program_reg(input logic [2:0] idx, input logic [15:0] value, input int w);
    logic [15:0] d;
    d = 16'($urandom) << w;
    d = d | value;
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    case (idx)
      CFG_TUNNEL_LIMIT: lim_tunnel = d[7:0];
      CFG_GROUND_LIMIT: lim_ground = d[7:0];
      CFG_OBJECT_LIMIT: lim_object = d[7:0];
      CFG_HOLD_TIME:    lim_hold = d;
      CFG_HALL_LIMIT:   lim_hall = d[9:0];
      CFG_HALL_ENABLE:  hall_on = d[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (nav_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic offer(input item_t it, input logic known, input nav_result_t typed);
    nav_result_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= it.operation;
    now_ms <= it.now_ms;
    front_distance <= it.front_distance;
    left_distance <= it.left_distance;
    right_distance <= it.right_distance;
    ground_distance <= it.ground_distance;
    left_border_seen <= it.left_border_seen;
    right_border_seen <= it.right_border_seen;
    hall_level <= it.hall_level;
    command_mode <= it.command_mode;
    command_auto <= it.command_auto;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_step(it, r);
    nav_expect_q.push_back(known ? typed : r);
    sent++;
  endtask

  function automatic logic [7:0] pick_dist(input logic [7:0] lim, input int hit_pct);
    if ($urandom_range(0, 99) < hit_pct)
      return $urandom_range(0, 1) ? lim : 8'($urandom_range(0, int'(lim)));
    if (lim == 8'hFF) return 8'hFF;
    return 8'($urandom_range(int'(lim) + 1, 255));
  endfunction

  task automatic next_random(output item_t it);
    if ($urandom_range(0, 99) < 4) sim_ms = $urandom;
    else sim_ms = sim_ms + $urandom_range(0, int'(lim_hold) / 2 + 40);
    it.now_ms = sim_ms;
    it.operation = ($urandom_range(0, 99) < 7) ? OP_MANUAL : OP_SENSOR;
    it.command_mode = 4'($urandom_range(0, 15));
    it.command_auto = $urandom_range(0, 99) < 85;
    it.left_border_seen = $urandom_range(0, 99) < 12;
    it.right_border_seen = $urandom_range(0, 99) < 12;
    if ($urandom_range(0, 99) < 5) begin
      it.front_distance = 8'($urandom);
      it.left_distance = 8'($urandom);
      it.right_distance = 8'($urandom);
      it.ground_distance = 8'($urandom);
      it.hall_level = 10'($urandom);
    end else begin
      it.front_distance = pick_dist(lim_object, 15);
      it.left_distance = pick_dist(lim_tunnel, 8);
      it.right_distance = pick_dist(lim_tunnel, 8);
      it.ground_distance = pick_dist(lim_ground, 88);
      if ($urandom_range(0, 99) < 10)
        it.hall_level = 10'($urandom_range(0, int'(lim_hall)));
      else
        it.hall_level = 10'($urandom_range(int'(lim_hall), 1023));
    end
  endtask

  task automatic apply_setting(input int s);
    logic [7:0]  t_lim;
    logic [7:0]  g_lim;
    logic [7:0]  o_lim;
    logic [15:0] h_time;
    logic [9:0]  h_lim;
    logic        h_en;
    case (s)
      0: begin
        t_lim = 8'd5; g_lim = 8'd10; o_lim = 8'd20; h_time = 16'd2500;
        h_lim = 10'd561; h_en = 1'b1;
      end
      1: begin
        t_lim = 8'd0; g_lim = 8'd0; o_lim = 8'd0; h_time = 16'd0;
        h_lim = 10'd0; h_en = 1'b0;
      end
      2: begin
        t_lim = 8'hFF; g_lim = 8'hFF; o_lim = 8'hFF; h_time = 16'hFFFF;
        h_lim = 10'h3FF; h_en = 1'b1;
      end
      4: begin
        t_lim = 8'd12; g_lim = 8'd200; o_lim = 8'd80; h_time = 16'd800;
        h_lim = 10'd300; h_en = 1'b1;
      end
      default: begin
        t_lim = 8'($urandom_range(0, 30));
        g_lim = 8'($urandom);
        o_lim = 8'($urandom_range(0, 60));
        h_time = 16'($urandom_range(0, 400));
        h_lim = 10'($urandom);
        h_en = 1'($urandom);
      end
    endcase
    drain();
    program_reg(CFG_TUNNEL_LIMIT, {8'd0, t_lim}, 8);
    program_reg(CFG_GROUND_LIMIT, {8'd0, g_lim}, 8);
    program_reg(CFG_OBJECT_LIMIT, {8'd0, o_lim}, 8);
    program_reg(CFG_HOLD_TIME, h_time, 16);
    program_reg(CFG_HALL_LIMIT, {6'd0, h_lim}, 10);
    program_reg(CFG_HALL_ENABLE, {15'd0, h_en}, 1);
    if (s == 0) begin
      program_reg(CFG_SPARE_A, 16'($urandom), 16);
      program_reg(CFG_SPARE_B, 16'($urandom), 16);
    end
    cfg_write <= 1'b0;
  endtask

  // result checker and receiver throttle
  initial begin
    nav_result_t got;
    nav_result_t want;
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_valid && out_ready) begin
          got.mode = mode;
          got.side = border_side;
          got.pins = {right_enable, right_backward, right_forward,
                      left_enable, left_backward, left_forward};
          got.changed = mode_changed;
          if (nav_expect_q.size() == 0) begin
            flag("unexpected transaction", '0, got);
          end else begin
            want = nav_expect_q.pop_front();
            if (got.mode !== want.mode || got.side !== want.side ||
                got.pins !== want.pins || got.changed !== want.changed)
              flag("result", want, got);
          end
          results_seen++;
          if (results_seen % 400 == 150) stall_left = STALL_CYCLES;
        end
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
      end
    end
  end

  initial begin
    item_t       it;
    script_row_t row;
    errors = 0;
    sent = 0;
    results_seen = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    modes_hit = '0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    operation <= OP_SENSOR;
    now_ms <= '0;
    front_distance <= '0;
    left_distance <= '0;
    right_distance <= '0;
    ground_distance <= '0;
    left_border_seen <= 1'b0;
    right_border_seen <= 1'b0;
    hall_level <= '0;
    command_mode <= MODE_STILL;
    command_auto <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_TUNNEL_LIMIT;
    cfg_data <= '0;

    cur_mode = MODE_FORWARD;
    mode_since = '0;
    last_side = 1'b0;
    autonomous = 1'b0;
    drive_pins = PINS_STOP;
    lim_tunnel = TUNNEL_LIMIT_RST;
    lim_ground = GROUND_LIMIT_RST;
    lim_object = OBJECT_LIMIT_RST;
    lim_hold = HOLD_TIME_RST;
    lim_hall = HALL_LIMIT_RST;
    hall_on = 1'b0;

    add(sense(32'd0, 8'd200, 8'd200, 8'd200, 8'd0, 1'b0, 1'b0, 10'd1023), 1'b1,
        shows(MODE_FORWARD, 1'b0, PINS_STOP, 1'b0));
    add(sense(32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b1, 10'd0), 1'b1,
        shows(MODE_FORWARD, 1'b0, PINS_STOP, 1'b0));
    add(manual(32'd100, MODE_FORWARD, 1'b1), 1'b1, shows(MODE_FORWARD, 1'b0, PINS_STOP, 1'b0));
    add(manual(32'd150, MODE_STILL, 1'b1), 1'b1, shows(MODE_STILL, 1'b0, PINS_STOP, 1'b0));
    add(sense(32'd200, 8'd200, 8'd200, 8'd200, 8'd0, 1'b0, 1'b0, 10'd1023), 1'b0, '0);
    add(manual(32'd300, MODE_FORWARD, 1'b1), 1'b1, shows(MODE_FORWARD, 1'b0, PINS_FWD, 1'b0));
    add(sense(32'd400, 8'd200, 8'd0, 8'd200, 8'd0, 1'b0, 1'b0, 10'd1023), 1'b1,
        shows(MODE_TUNNEL_LEFT, 1'b0, PINS_RIGHT, 1'b1));
    add(sense(32'd500, 8'd200, 8'd200, 8'd200, 8'd0, 1'b0, 1'b0, 10'd1023), 1'b0, '0);
    add(sense(32'd600, 8'd200, 8'd200, 8'd5, 8'd0, 1'b0, 1'b0, 10'd1023), 1'b0, '0);
    add(sense(32'd700, 8'd200, 8'd200, 8'd6, 8'd0, 1'b0, 1'b0, 10'd1023), 1'b0, '0);
    add(sense(32'd800, 8'd200, 8'd200, 8'd200, 8'd0, 1'b1, 1'b1, 10'd1023), 1'b0, '0);
    add(sense(32'd3300, 8'd200, 8'd200, 8'd200, 8'd0, 1'b0, 1'b0, 10'd1023), 1'b0, '0);
    add(sense(32'd3301, 8'd200, 8'd200, 8'd200, 8'd0, 1'b0, 1'b0, 10'd1023), 1'b0, '0);
    add(sense(32'd3350, 8'd200, 8'd200, 8'd200, 8'd10, 1'b0, 1'b0, 10'd1023), 1'b0, '0);
    add(sense(32'd3400, 8'd200, 8'd200, 8'd200, 8'd11, 1'b0, 1'b0, 10'd1023), 1'b0, '0);
    add(sense(32'd3500, 8'd200, 8'd200, 8'd200, 8'd0, 1'b1, 1'b0, 10'd1023), 1'b0, '0);
    add(sense(32'd3600, 8'd200, 8'd200, 8'd200, 8'd0, 1'b0, 1'b1, 10'd1023), 1'b0, '0);
    add(sense(32'd3650, 8'd200, 8'd200, 8'd200, 8'd0, 1'b0, 1'b1, 10'd1023), 1'b0, '0);
    add(sense(32'd3700, 8'd20, 8'd200, 8'd200, 8'd0, 1'b0, 1'b0, 10'd1023), 1'b0, '0);
    add(sense(32'hFFFF_FFFF, 8'd21, 8'd200, 8'd200, 8'd0, 1'b0, 1'b0, 10'd1023), 1'b0, '0);
    add_cfg(CFG_HALL_ENABLE, 16'd1);
    add(sense(32'd1000, 8'd200, 8'd0, 8'd200, 8'd0, 1'b0, 1'b0, 10'd560), 1'b1,
        shows(MODE_MAGNET, 1'b1, PINS_STOP, 1'b1));
    add(sense(32'd0, 8'd200, 8'd200, 8'd200, 8'd0, 1'b0, 1'b0, 10'd1023), 1'b1,
        shows(MODE_MAGNET, 1'b1, PINS_STOP, 1'b0));
    add(sense(32'd2000, 8'd200, 8'd0, 8'd200, 8'd0, 1'b0, 1'b0, 10'd561), 1'b0, '0);
    add(manual(32'd2100, MODE_TUNNEL_RIGHT, 1'b0), 1'b1,
        shows(MODE_TUNNEL_RIGHT, 1'b1, PINS_LEFT, 1'b0));
    add(sense(32'd2200, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b1, 10'd0), 1'b1,
        shows(MODE_TUNNEL_RIGHT, 1'b1, PINS_LEFT, 1'b0));
    add(manual(32'd2300, MODE_STILL, 1'b1), 1'b0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 29;
    recv_idle_pct = 66;
    foreach (script_q[k]) begin
      row = script_q[k];
      if (row.is_cfg) begin
        drain();
        program_reg(row.idx, row.val, 1);
        cfg_write <= 1'b0;
      end else begin
        offer(row.it, row.known, row.res);
      end
    end

    sim_ms = $urandom;
    for (int s = 0; s < 6; s++) begin
      if (s < 2) begin
        send_idle_pct = 29;
        recv_idle_pct = 66;
      end else if (s < 4) begin
        send_idle_pct = 66;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_setting(s);
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        next_random(it);
        offer(it, 1'b0, '0);
      end
    end

    drain();
    $display("covered %0d transactions (%0d scripted) under 6 limit settings, %0d results checked",
             sent, script_q.size() - 1, results_seen);
    $display("navigation modes entered: %0d of 16, mismatches: %0d", $countones(modes_hit), errors);
    if (errors == 0 && nav_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/rav_pkg.sv
rtl/core/rav_nav.sv
rtl/core/rover_avoidance_fsm.sv
sim/tb.sv
